>>> rtl/core/szpr_pkg.sv
// shared types and constants of the spectrum zero pad resample unit
package szpr_pkg;

    localparam int unsigned DEF_MAX_WIDTH  = 64;
    localparam int unsigned DEF_MAX_HEIGHT = 64;
    localparam int unsigned QUEUE_DEPTH    = 2;

    localparam int unsigned DATA_W = 32;
    localparam int unsigned SIZE_W = 7;
    localparam int unsigned POS_W  = 6;
    localparam int unsigned CFG_W  = 2;

    localparam logic [CFG_W-1:0] CFG_IN_WIDTH   = 2'd0;
    localparam logic [CFG_W-1:0] CFG_IN_HEIGHT  = 2'd1;
    localparam logic [CFG_W-1:0] CFG_OUT_WIDTH  = 2'd2;
    localparam logic [CFG_W-1:0] CFG_OUT_HEIGHT = 2'd3;

    typedef enum logic [1:0] {
        OP_LOAD  = 2'd0,
        OP_ZERO  = 2'd1,
        OP_SUM   = 2'd2,
        OP_SPLIT = 2'd3
    } t_op;

    typedef struct packed {
        t_op                op;
        logic [SIZE_W-1:0]  hk;
        logic [SIZE_W-1:0]  hkk;
        logic [SIZE_W-1:0]  vk;
        logic [SIZE_W-1:0]  vkk;
        logic               hcol;
        logic               vcol;
        logic [1:0]         shift;
        logic [DATA_W-1:0]  re;
        logic [DATA_W-1:0]  im;
    } t_entry;

endpackage

>>> rtl/core/spectrum_zero_pad_resample_unit.sv
// top level of the spectrum zero pad resample unit
// Load transactions write one complex Q16.16 coefficient into the spectrum memory and give
// no result; fetch transactions give one resized output coefficient each. The front end
// classifies each transaction in the cycle it is accepted and places it in a two-entry
// queue, so input is taken while that queue has room. In the back end a load and a fetch
// that gives zero are handled in the idle state; any other fetch reads one, two or four
// stored coefficients in the read state, as the single-port spectrum memory gives one
// coefficient a cycle, then passes the wait and done states. A finished result waits in
// an output register while the back end carries on. Size writes are clamped to the range
// 1 to the memory dimension and must only be made while the unit is idle. The memory is
// not cleared: fetch only coefficients that were loaded.
module spectrum_zero_pad_resample_unit #(
    parameter int unsigned MAX_WIDTH  = szpr_pkg::DEF_MAX_WIDTH,
    parameter int unsigned MAX_HEIGHT = szpr_pkg::DEF_MAX_HEIGHT
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [szpr_pkg::CFG_W-1:0]    i_cfg_idx,
    input  logic [szpr_pkg::SIZE_W-1:0]   i_cfg_data,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic                          i_mode,
    input  logic [szpr_pkg::POS_W-1:0]    i_col,
    input  logic [szpr_pkg::POS_W-1:0]    i_row,
    input  logic [szpr_pkg::DATA_W-1:0]   i_real_in,
    input  logic [szpr_pkg::DATA_W-1:0]   i_imag_in,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [szpr_pkg::DATA_W-1:0]   o_real_out,
    output logic [szpr_pkg::DATA_W-1:0]   o_imag_out
);

    logic             q_push, q_pop, q_full, q_valid;
    szpr_pkg::t_entry q_in, q_head;

    szpr_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_valid    (i_in_valid),
        .o_ready    (o_in_ready),
        .i_mode     (i_mode),
        .i_col      (i_col),
        .i_row      (i_row),
        .i_real_in  (i_real_in),
        .i_imag_in  (i_imag_in),
        .i_full     (q_full),
        .o_push     (q_push),
        .o_entry    (q_in)
    );

    szpr_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_entry (q_in),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_head  (q_head)
    );

    szpr_back #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head_valid (q_valid),
        .i_head       (q_head),
        .o_pop        (q_pop),
        .o_valid      (o_out_valid),
        .i_ready      (i_out_ready),
        .o_real       (o_real_out),
        .o_imag       (o_imag_out)
    );

endmodule

>>> rtl/core/szpr_front.sv
// front end: size registers, item classification and index mapping
module szpr_front #(
    parameter int unsigned MAX_WIDTH  = szpr_pkg::DEF_MAX_WIDTH,
    parameter int unsigned MAX_HEIGHT = szpr_pkg::DEF_MAX_HEIGHT
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [szpr_pkg::CFG_W-1:0]    i_cfg_idx,
    input  logic [szpr_pkg::SIZE_W-1:0]   i_cfg_data,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic                          i_mode,
    input  logic [szpr_pkg::POS_W-1:0]    i_col,
    input  logic [szpr_pkg::POS_W-1:0]    i_row,
    input  logic [szpr_pkg::DATA_W-1:0]   i_real_in,
    input  logic [szpr_pkg::DATA_W-1:0]   i_imag_in,
    input  logic                          i_full,
    output logic                          o_push,
    output szpr_pkg::t_entry              o_entry
);

    typedef enum logic [1:0] {
        AX_ZERO     = 2'd0,
        AX_PLAIN    = 2'd1,
        AX_COLLAPSE = 2'd2,
        AX_SPLIT    = 2'd3
    } t_kind;

    typedef struct packed {
        t_kind                        kind;
        logic [szpr_pkg::SIZE_W-1:0]  k;
        logic [szpr_pkg::SIZE_W-1:0]  kk;
    } t_axis;

    function automatic logic [szpr_pkg::SIZE_W-1:0] clamp_size(
        input logic [szpr_pkg::SIZE_W-1:0] v,
        input int unsigned                 max
    );
        logic [szpr_pkg::SIZE_W-1:0] s;
        s = (v == '0) ? szpr_pkg::SIZE_W'(1) : v;
        if (32'(s) > max) begin
            s = szpr_pkg::SIZE_W'(max);
        end
        return s;
    endfunction

    function automatic t_axis axis_map(
        input logic [szpr_pkg::POS_W-1:0]  idx,
        input logic [szpr_pkg::SIZE_W-1:0] n_out,
        input logic [szpr_pkg::SIZE_W-1:0] n_in
    );
        logic        [8:0] idx9;
        logic        [8:0] n_in9;
        logic signed [8:0] f;
        logic signed [8:0] neg_f;
        logic signed [8:0] lo;
        logic signed [8:0] hi;
        t_axis             a;
        idx9  = 9'(idx);
        n_in9 = 9'(n_in);
        if (idx9 < 9'(n_out - (n_out >> 1))) begin
            f = signed'(idx9);
        end else begin
            f = signed'(idx9 - 9'(n_out));
        end
        neg_f  = -f;
        lo     = -signed'(9'(n_in >> 1));
        hi     = signed'(n_in9 - 9'(n_in >> 1));
        a.kind = AX_PLAIN;
        a.k    = '0;
        a.kk   = '0;
        if (n_out > n_in && !n_in[0] && (f == lo || f == -lo)) begin
            a.kind = AX_SPLIT;
            a.k    = n_in >> 1;
        end else if (f < lo || f >= hi) begin
            a.kind = AX_ZERO;
        end else begin
            a.k  = f[8] ? szpr_pkg::SIZE_W'(n_in9 + 9'(f)) : szpr_pkg::SIZE_W'(f);
            a.kk = neg_f[8] ? szpr_pkg::SIZE_W'(n_in9 + 9'(neg_f))
                            : szpr_pkg::SIZE_W'(neg_f);
            if (n_out < n_in && !n_out[0] && f == -signed'(9'(n_out >> 1))) begin
                a.kind = AX_COLLAPSE;
            end
        end
        return a;
    endfunction

    logic [szpr_pkg::SIZE_W-1:0] r_in_w, r_in_h, r_out_w, r_out_h;
    t_axis                       hax, vax;
    logic                        keep;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_w  <= clamp_size(szpr_pkg::SIZE_W'(64), MAX_WIDTH);
            r_in_h  <= clamp_size(szpr_pkg::SIZE_W'(64), MAX_HEIGHT);
            r_out_w <= clamp_size(szpr_pkg::SIZE_W'(64), MAX_WIDTH);
            r_out_h <= clamp_size(szpr_pkg::SIZE_W'(64), MAX_HEIGHT);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                szpr_pkg::CFG_IN_WIDTH:   r_in_w  <= clamp_size(i_cfg_data, MAX_WIDTH);
                szpr_pkg::CFG_IN_HEIGHT:  r_in_h  <= clamp_size(i_cfg_data, MAX_HEIGHT);
                szpr_pkg::CFG_OUT_WIDTH:  r_out_w <= clamp_size(i_cfg_data, MAX_WIDTH);
                szpr_pkg::CFG_OUT_HEIGHT: r_out_h <= clamp_size(i_cfg_data, MAX_HEIGHT);
                default: ;
            endcase
        end
    end

    assign hax = axis_map(i_col, r_out_w, r_in_w);
    assign vax = axis_map(i_row, r_out_h, r_in_h);

    always_comb begin
        o_entry       = '0;
        o_entry.re    = i_real_in;
        o_entry.im    = i_imag_in;
        keep          = 1'b1;
        if (!i_mode) begin
            o_entry.op = szpr_pkg::OP_LOAD;
            o_entry.hk = szpr_pkg::SIZE_W'(i_col);
            o_entry.vk = szpr_pkg::SIZE_W'(i_row);
            keep = (szpr_pkg::SIZE_W'(i_col) < r_in_w) && (szpr_pkg::SIZE_W'(i_row) < r_in_h);
        end else if (szpr_pkg::SIZE_W'(i_col) >= r_out_w ||
                     szpr_pkg::SIZE_W'(i_row) >= r_out_h ||
                     hax.kind == AX_ZERO || vax.kind == AX_ZERO) begin
            o_entry.op = szpr_pkg::OP_ZERO;
        end else begin
            o_entry.hk  = hax.k;
            o_entry.hkk = hax.kk;
            o_entry.vk  = vax.k;
            o_entry.vkk = vax.kk;
            if (hax.kind == AX_SPLIT || vax.kind == AX_SPLIT) begin
                o_entry.op    = szpr_pkg::OP_SPLIT;
                o_entry.shift = {1'b0, hax.kind == AX_SPLIT} + {1'b0, vax.kind == AX_SPLIT};
            end else begin
                o_entry.op   = szpr_pkg::OP_SUM;
                o_entry.hcol = (hax.kind == AX_COLLAPSE);
                o_entry.vcol = (vax.kind == AX_COLLAPSE);
            end
        end
    end

    assign o_ready = !i_full;
    assign o_push  = i_valid && !i_full && keep;

endmodule

>>> rtl/core/szpr_fifo.sv
// short queue of classified transactions between front and back end
module szpr_fifo (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  szpr_pkg::t_entry i_entry,
    input  logic             i_pop,
    output logic             o_full,
    output logic             o_valid,
    output szpr_pkg::t_entry o_head
);

    localparam int unsigned PW = (szpr_pkg::QUEUE_DEPTH > 1) ? $clog2(szpr_pkg::QUEUE_DEPTH) : 1;
    localparam int unsigned CW = $clog2(szpr_pkg::QUEUE_DEPTH + 1);

    szpr_pkg::t_entry r_slot [szpr_pkg::QUEUE_DEPTH];
    logic [PW-1:0]    r_wr_ptr, r_rd_ptr;
    logic [CW-1:0]    r_count;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PW'(szpr_pkg::QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PW'(szpr_pkg::QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    assign o_full  = (r_count == CW'(szpr_pkg::QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_head  = r_slot[r_rd_ptr];

endmodule

>>> rtl/core/szpr_back.sv
// back end: spectrum memory, term read sequencer, accumulator and result register
module szpr_back #(
    parameter int unsigned MAX_WIDTH  = szpr_pkg::DEF_MAX_WIDTH,
    parameter int unsigned MAX_HEIGHT = szpr_pkg::DEF_MAX_HEIGHT
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_head_valid,
    input  szpr_pkg::t_entry             i_head,
    output logic                         o_pop,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic [szpr_pkg::DATA_W-1:0]  o_real,
    output logic [szpr_pkg::DATA_W-1:0]  o_imag
);

    localparam int unsigned DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int unsigned AW    = $clog2(DEPTH);
    localparam int unsigned ACC_W = szpr_pkg::DATA_W + 2;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_READ = 4'b0010,
        S_WAIT = 4'b0100,
        S_DONE = 4'b1000
    } t_state;

    function automatic logic [szpr_pkg::DATA_W-1:0] sat32(input logic signed [ACC_W-1:0] v);
        logic [szpr_pkg::DATA_W-1:0] r;
        if (v[ACC_W-1:ACC_W-3] == 3'b000 || v[ACC_W-1:ACC_W-3] == 3'b111) begin
            r = v[szpr_pkg::DATA_W-1:0];
        end else if (v[ACC_W-1]) begin
            r = {1'b1, {(szpr_pkg::DATA_W-1){1'b0}}};
        end else begin
            r = {1'b0, {(szpr_pkg::DATA_W-1){1'b1}}};
        end
        return r;
    endfunction

    logic [2*szpr_pkg::DATA_W-1:0] mem [DEPTH];
    logic [2*szpr_pkg::DATA_W-1:0] r_rd_data;

    t_state                        r_state, n_state;
    szpr_pkg::t_entry              r_job, n_job;
    logic [1:0]                    r_term, n_term;
    logic                          r_rd_vld;
    logic signed [ACC_W-1:0]       r_acc_re, r_acc_im;
    logic                          r_out_valid, n_out_valid;
    logic [szpr_pkg::DATA_W-1:0]   r_out_re, n_out_re, r_out_im, n_out_im;

    logic                          out_free;
    logic                          mem_we;
    logic [AW-1:0]                 mem_addr;
    logic [szpr_pkg::SIZE_W-1:0]   sel_h, sel_v;
    logic [1:0]                    last_term;
    logic                          acc_clr;
    logic signed [szpr_pkg::DATA_W-1:0] rd_re, rd_im;

    assign out_free  = !r_out_valid || i_ready;
    assign last_term = {r_job.vcol & r_job.hcol, r_job.vcol | r_job.hcol};

    always_comb begin
        if (r_state == S_READ) begin
            sel_v = (r_job.vcol && r_term[0]) ? r_job.vkk : r_job.vk;
            sel_h = (r_job.hcol && (r_job.vcol ? r_term[1] : r_term[0])) ? r_job.hkk : r_job.hk;
        end else begin
            sel_v = i_head.vk;
            sel_h = i_head.hk;
        end
        mem_addr = AW'(AW'(sel_v) * AW'(MAX_WIDTH)) + AW'(sel_h);
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_addr] <= {i_head.re, i_head.im};
        end
        r_rd_data <= mem[mem_addr];
    end

    always_comb begin
        n_state     = r_state;
        n_job       = r_job;
        n_term      = r_term;
        n_out_valid = r_out_valid && !i_ready;
        n_out_re    = r_out_re;
        n_out_im    = r_out_im;
        o_pop       = 1'b0;
        mem_we      = 1'b0;
        acc_clr     = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_head_valid) begin
                    case (i_head.op)
                        szpr_pkg::OP_LOAD: begin
                            mem_we = 1'b1;
                            o_pop  = 1'b1;
                        end
                        szpr_pkg::OP_ZERO: begin
                            if (out_free) begin
                                o_pop       = 1'b1;
                                n_out_valid = 1'b1;
                                n_out_re    = '0;
                                n_out_im    = '0;
                            end
                        end
                        default: begin
                            o_pop   = 1'b1;
                            n_job   = i_head;
                            n_term  = '0;
                            acc_clr = 1'b1;
                            n_state = S_READ;
                        end
                    endcase
                end
            end
            S_READ: begin
                if (r_term == last_term) begin
                    n_state = S_WAIT;
                end else begin
                    n_term = r_term + 1'b1;
                end
            end
            S_WAIT: begin
                n_state = S_DONE;
            end
            S_DONE: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_re    = sat32(r_acc_re);
                    n_out_im    = sat32(r_acc_im);
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign rd_re = signed'(r_rd_data[2*szpr_pkg::DATA_W-1:szpr_pkg::DATA_W]);
    assign rd_im = signed'(r_rd_data[szpr_pkg::DATA_W-1:0]);

    always_ff @(posedge i_clk) begin
        r_job    <= n_job;
        r_term   <= n_term;
        r_out_re <= n_out_re;
        r_out_im <= n_out_im;
        if (acc_clr) begin
            r_acc_re <= '0;
            r_acc_im <= '0;
        end else if (r_rd_vld) begin
            if (r_job.op == szpr_pkg::OP_SPLIT) begin
                r_acc_re <= ACC_W'(rd_re >>> r_job.shift);
                r_acc_im <= '0;
            end else begin
                r_acc_re <= r_acc_re + ACC_W'(rd_re);
                r_acc_im <= r_acc_im + ACC_W'(rd_im);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_rd_vld    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_rd_vld    <= (r_state == S_READ);
            r_out_valid <= n_out_valid;
        end
    end

    assign o_valid = r_out_valid;
    assign o_real  = r_out_re;
    assign o_imag  = r_out_im;

endmodule
